>>> sv/pwps_pkg.sv
// ----------------------------------------------------------------------------
// pwps_pkg
// Widths, types and reset constants shared by the weighted patch sum
// block and its channel interfaces.
// ----------------------------------------------------------------------------
package pwps_pkg;

    localparam int PSF_W   = 16;
    localparam int IMG_W   = 16;
    localparam int PW_W    = 24;
    localparam int EMI_W   = 24;
    localparam int PSUM_W  = 26;
    localparam int WSUM_W  = 42;
    localparam int CHUNK_W = 16;
    localparam int MUL_W   = CHUNK_W + PW_W;
    localparam int PROD_W  = WSUM_W + PW_W;
    localparam int QUO_W   = EMI_W;

    localparam logic [PW_W-1:0] PW_RESET = 24'd65536;

    typedef logic [PSF_W-1:0]  t_psf;
    typedef logic [IMG_W-1:0]  t_img;
    typedef logic [PW_W-1:0]   t_pw;
    typedef logic [EMI_W-1:0]  t_emission;
    typedef logic [PSUM_W-1:0] t_psum;
    typedef logic [WSUM_W-1:0] t_wsum;
    typedef logic [PROD_W-1:0] t_prod;

endpackage

>>> sv/pwps_if.sv
// ----------------------------------------------------------------------------
// pwps channel interfaces
// Valid/ready channels for pixel requests, results and the register write.
// ----------------------------------------------------------------------------
interface pwps_in_if;
    import pwps_pkg::*;
    logic valid;
    logic ready;
    t_psf psf_value;
    t_img image_value;
    logic last_pixel;
    modport source (output valid, output psf_value, output image_value,
                    output last_pixel, input ready);
    modport sink   (input valid, input psf_value, input image_value,
                    input last_pixel, output ready);
endinterface

interface pwps_out_if;
    import pwps_pkg::*;
    logic      valid;
    logic      ready;
    t_emission emission;
    logic      zero_weight_sum;
    modport source (output valid, output emission, output zero_weight_sum,
                    input ready);
    modport sink   (input valid, input emission, input zero_weight_sum,
                    output ready);
endinterface

interface pwps_cfg_if;
    import pwps_pkg::*;
    logic valid;
    logic ready;
    t_pw  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/psf_weighted_patch_sum.sv
// ----------------------------------------------------------------------------
// psf_weighted_patch_sum
// PSF weighted aperture photometry: sums weights and weight*sample over a
// patch and reports weighted_total * projection_weight / (psf_total * 2^16).
// ----------------------------------------------------------------------------
// Pixel requests are taken one per cycle while the block is idle; each one
// updates both running sums through a single 16x24 multiplier. The request
// marked last_pixel then keeps the block busy: three partial products
// through the same multiplier form the 66-bit product, a check state
// tests for saturation, and a restoring divider resolves one quotient bit
// per cycle for all 24 bits; the divide is skipped when the result
// saturates, and the whole sequence when the weight sum is zero. A finished
// result sits in an output register, so the next patch may start while
// it waits. The projection weight write port is always ready.
module psf_weighted_patch_sum (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pwps_in_if.sink   i_pix,
    pwps_cfg_if.sink  i_cfg,
    pwps_out_if.source o_res
);
    import pwps_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [4:0] MUL_LAST = 5'd2;
    localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    t_psum       r_psum, n_psum;
    t_wsum       r_wsum, n_wsum;
    t_pw         r_pw, n_pw;
    t_prod       r_prod, n_prod;
    t_psum       r_rem, n_rem;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic        r_sat, n_sat;
    logic        r_zero, n_zero;
    logic        r_out_valid, n_out_valid;
    t_emission   r_emission, n_emission;
    logic        r_flag, n_flag;

    logic [CHUNK_W-1:0] mul_a;
    t_pw                mul_b;
    logic [MUL_W-1:0]   mul_p;
    logic [PSUM_W:0]    psum_add;
    logic [WSUM_W:0]    wsum_add;
    t_psum              psum_acc;
    t_wsum              wsum_acc;
    t_prod              prod_base;
    logic [PSUM_W:0]    trial;
    logic               trial_ge;
    logic               pix_acc;

    assign i_pix.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign pix_acc     = i_pix.valid && i_pix.ready;

    assign o_res.valid           = r_out_valid;
    assign o_res.emission        = r_emission;
    assign o_res.zero_weight_sum = r_flag;

    // shared multiplier operand select
    always_comb begin
        mul_a = i_pix.psf_value;
        mul_b = {{(PW_W-IMG_W){1'b0}}, i_pix.image_value};
        if (r_state == S_MUL) begin
            mul_b = r_pw;
            case (r_cnt[1:0])
                2'd0:    mul_a = {{(3*CHUNK_W-WSUM_W){1'b0}},
                                  r_wsum[WSUM_W-1:2*CHUNK_W]};
                2'd1:    mul_a = r_wsum[2*CHUNK_W-1:CHUNK_W];
                default: mul_a = r_wsum[CHUNK_W-1:0];
            endcase
        end
    end

    assign mul_p = {{PW_W{1'b0}}, mul_a} * {{CHUNK_W{1'b0}}, mul_b};

    assign psum_add = {1'b0, r_psum} + {{(PSUM_W+1-PSF_W){1'b0}}, i_pix.psf_value};
    assign wsum_add = {1'b0, r_wsum}
                    + {{(WSUM_W+1-PSF_W-IMG_W){1'b0}}, mul_p[PSF_W+IMG_W-1:0]};
    assign psum_acc = psum_add[PSUM_W] ? {PSUM_W{1'b1}} : psum_add[PSUM_W-1:0];
    assign wsum_acc = wsum_add[WSUM_W] ? {WSUM_W{1'b1}} : wsum_add[WSUM_W-1:0];

    assign prod_base = (r_cnt == 5'd0) ? '0 : {r_prod[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};

    assign trial    = {r_rem, r_prod[PROD_W-PSUM_W-1]};
    assign trial_ge = (trial >= {1'b0, r_psum});

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_psum      = r_psum;
        n_wsum      = r_wsum;
        n_pw        = r_pw;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_sat       = r_sat;
        n_zero      = r_zero;
        n_out_valid = r_out_valid;
        n_emission  = r_emission;
        n_flag      = r_flag;

        if (i_cfg.valid && i_cfg.ready) begin
            n_pw = i_cfg.data;
        end
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (pix_acc) begin
                    n_psum = psum_acc;
                    n_wsum = wsum_acc;
                    n_cnt  = 5'd0;
                    if (i_pix.last_pixel) begin
                        n_zero  = (psum_acc == '0);
                        n_state = (psum_acc == '0) ? S_DONE : S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_prod = prod_base + {{(PROD_W-MUL_W){1'b0}}, mul_p};
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_sat   = (r_prod[PROD_W-1:PROD_W-PSUM_W] >= r_psum);
                n_rem   = r_prod[PROD_W-1:PROD_W-PSUM_W];
                n_cnt   = 5'd0;
                n_state = (r_prod[PROD_W-1:PROD_W-PSUM_W] >= r_psum) ? S_DONE : S_DIV;
            end
            S_DIV: begin
                n_rem  = trial_ge ? PSUM_W'(trial - {1'b0, r_psum}) : trial[PSUM_W-1:0];
                n_quo  = {r_quo[QUO_W-2:0], trial_ge};
                n_prod = {r_prod[PROD_W-2:0], 1'b0};
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_flag      = r_zero;
                    if (r_zero) begin
                        n_emission = '0;
                    end else if (r_sat) begin
                        n_emission = {EMI_W{1'b1}};
                    end else begin
                        n_emission = r_quo;
                    end
                    n_psum  = '0;
                    n_wsum  = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_psum      <= '0;
            r_wsum      <= '0;
            r_pw        <= PW_RESET;
            r_sat       <= 1'b0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_psum      <= n_psum;
            r_wsum      <= n_wsum;
            r_pw        <= n_pw;
            r_sat       <= n_sat;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_emission <= n_emission;
        r_flag     <= n_flag;
    end

endmodule

>>> sv/pwps_chk.sv
// ----------------------------------------------------------------------------
// pwps_chk
// Port level checks for psf_weighted_patch_sum, attached by bind.
// ----------------------------------------------------------------------------
module pwps_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_in_last,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input pwps_pkg::t_emission    i_emission,
    input logic                   i_zero_flag
);
    import pwps_pkg::*;

    // held result request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_emission) && $stable(i_zero_flag))
        else $error("result changed while stalled");

    // zero weight sum reports a zero estimate
    a_zero_emission: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero_flag |-> i_emission == '0)
        else $error("zero weight sum with nonzero emission");

    // end of patch makes the block busy
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("ready right after last pixel");

endmodule

bind psf_weighted_patch_sum pwps_chk u_pwps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_last   (i_pix.last_pixel),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_emission  (o_res.emission),
    .i_zero_flag (o_res.zero_weight_sum)
);

>>> bench/psf_weighted_patch_sum_tb.sv
// ----------------------------------------------------------------------------
// psf_weighted_patch_sum_tb
// Self-checking bench for the weighted patch sum block. Pixel requests go
// in through valid/ready channels with random gaps and output stalls. A
// scoreboard keeps its own copy of both running sums and the projection
// weight, predicts every emission, and compares each result in order.
// ----------------------------------------------------------------------------
module psf_weighted_patch_sum_tb;
    import pwps_pkg::*;

    localparam int PATCH_SIDE   = 31;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int WIDE_W       = 128;

    localparam logic [WIDE_W-1:0] EMIT_LIMIT = {{(WIDE_W-EMI_W){1'b0}}, {EMI_W{1'b1}}};

    typedef struct packed {
        t_emission emission;
        logic      zero_weight_sum;
    } t_patch_result;

    class emission_scoreboard;
        t_psum         psf_total;
        t_wsum         weighted_total;
        t_pw           weight;
        t_patch_result expected_q[$];
        int            mismatches;
        int            checked;
        int            zero_patches;

        function new();
            psf_total      = '0;
            weighted_total = '0;
            weight         = PW_RESET;
            mismatches     = 0;
            checked        = 0;
            zero_patches   = 0;
        endfunction

        function void set_weight(t_pw w);
            weight = w;
        endfunction

        function void note_pixel(t_psf p, t_img v, logic last);
            logic [PSUM_W:0]   psum_next;
            logic [WSUM_W:0]   wsum_next;
            logic [WIDE_W-1:0] num;
            logic [WIDE_W-1:0] den;
            logic [WIDE_W-1:0] quo;
            t_patch_result     r;
            psum_next = {1'b0, psf_total} + {{(PSUM_W+1-PSF_W){1'b0}}, p};
            psf_total = psum_next[PSUM_W] ? '1 : psum_next[PSUM_W-1:0];
            wsum_next = {1'b0, weighted_total}
                      + ({{(WSUM_W+1-PSF_W){1'b0}}, p} * {{(WSUM_W+1-IMG_W){1'b0}}, v});
            weighted_total = wsum_next[WSUM_W] ? '1 : wsum_next[WSUM_W-1:0];
            if (!last)
                return;
            if (psf_total == '0) begin
                r.emission        = '0;
                r.zero_weight_sum = 1'b1;
                zero_patches++;
            end else begin
                num = {{(WIDE_W-WSUM_W){1'b0}}, weighted_total}
                    * {{(WIDE_W-PW_W){1'b0}}, weight};
                den = {{(WIDE_W-PSUM_W){1'b0}}, psf_total} << 16;
                quo = num / den;
                r.emission        = (quo > EMIT_LIMIT) ? '1 : quo[EMI_W-1:0];
                r.zero_weight_sum = 1'b0;
            end
            expected_q.push_back(r);
            psf_total      = '0;
            weighted_total = '0;
        endfunction

        function void check_emission(t_emission e, logic z);
            t_patch_result r;
            if (expected_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: emission=%0d zero_weight_sum=%0b", e, z);
                mismatches++;
                return;
            end
            r = expected_q.pop_front();
            checked++;
            if (r.emission !== e || r.zero_weight_sum !== z) begin
                if (mismatches < MAX_REPORTS)
                    $display("mismatch on result %0d: expected emission=%0d zero=%0b,",
                             checked, r.emission, r.zero_weight_sum,
                             " got %0d %0b", e, z);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pwps_in_if  pix ();
    pwps_cfg_if cfg ();
    pwps_out_if res ();

    emission_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int pixels_sent    = 0;
    int patches_sent   = 0;
    int weight_writes  = 0;

    psf_weighted_patch_sum dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // accepted requests and results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix.valid && pix.ready)
                sb.note_pixel(pix.psf_value, pix.image_value, pix.last_pixel);
            if (res.valid && res.ready)
                sb.check_emission(res.emission, res.zero_weight_sum);
            if (cfg.valid && cfg.ready)
                sb.set_weight(cfg.data);
        end
    end

    // result sink with random stalls and long hold-offs
    initial begin
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                res.ready <= 1'b0;
                hold_left--;
            end else begin
                res.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_pixel(t_psf p, t_img v, logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.valid       <= 1'b1;
        pix.psf_value   <= p;
        pix.image_value <= v;
        pix.last_pixel  <= last;
        do @(posedge i_clk); while (pix.ready !== 1'b1);
        pixels_sent++;
        if (last)
            patches_sent++;
    endtask

    task automatic write_weight(t_pw w);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.data  <= w;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        weight_writes++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        pix.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001 << $urandom_range(15);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_patch(int len, bit zero_psf);
        t_psf p;
        for (int i = 0; i < len; i++) begin
            p = zero_psf ? '0 : pick_value();
            send_pixel(p, pick_value(), i == len - 1);
        end
    endtask

    task automatic run_random(int n_items);
        int count;
        int len;
        count = 0;
        while (count < n_items) begin
            len = ($urandom_range(3) == 0) ? 1 : $urandom_range(24, 2);
            run_patch(len, $urandom_range(9) == 0);
            count += len;
        end
    endtask

    initial begin
        int send_mode[4];
        int recv_mode[4];
        t_pw phase_weight[4];
        send_mode    = '{0, 60, 0, 8};
        recv_mode    = '{0, 0, 60, 8};
        phase_weight = '{24'hFFFFFF, 24'd0, 24'd1, 24'($urandom)};

        pix.valid       = 1'b0;
        pix.psf_value   = '0;
        pix.image_value = '0;
        pix.last_pixel  = 1'b0;
        cfg.valid       = 1'b0;
        cfg.data        = '0;
        i_rst_n         = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset weight
        send_pixel(16'h0000, 16'hFFFF, 1'b1);
        send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'h0001, 16'hFFFF, 1'b1);
        send_pixel(16'h0001, 16'hFFFF, 1'b0);
        send_pixel(16'h0000, 16'h0000, 1'b0);
        send_pixel(16'h8000, 16'h1234, 1'b1);
        send_pixel(16'h0000, 16'hFFFF, 1'b0);
        send_pixel(16'h0000, 16'hAAAA, 1'b0);
        send_pixel(16'h0000, 16'h5555, 1'b1);
        send_pixel(16'hFFFF, 16'h0000, 1'b1);
        send_pixel(16'h5555, 16'hAAAA, 1'b0);
        send_pixel(16'hAAAA, 16'h5555, 1'b1);
        drain();
        // directed, extreme weights
        write_weight(24'hFFFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'h0001, 16'hFFFF, 1'b1);
        send_pixel(16'h0000, 16'h0001, 1'b1);
        drain();
        write_weight(24'h000000);
        send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'h0000, 16'hFFFF, 1'b1);
        drain();

        // random phases under each idling mode
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_mode[ph];
            recv_stall_pct = recv_mode[ph];
            write_weight(phase_weight[ph]);
            run_random(170);
            drain();
        end

        // output held off while single-pixel patches keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_weight(24'($urandom));
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            run_patch(1, 1'b0);
        drain();

        // one patch row at unit weight
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        write_weight(PW_RESET);
        run_patch(PATCH_SIDE, 1'b0);
        run_random(40);
        drain();

        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        $display("sent %0d pixels in %0d patches over %0d weight settings",
                 pixels_sent, patches_sent, weight_writes);
        $display("checked %0d results, %0d with zero weight sum, %0d mismatches",
                 sb.checked, sb.zero_patches, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("timeout waiting for results");
        $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
sv/pwps_pkg.sv
sv/pwps_if.sv
sv/psf_weighted_patch_sum.sv
sv/pwps_chk.sv
bench/psf_weighted_patch_sum_tb.sv
